// ----- src/tsws_pkg.sv -----
`default_nettype none

package tsws_pkg;

  localparam int SECTOR_SHIFT     = 9;
  localparam int MAX_SEGMENTS_DEF = 16;

  localparam int SEG_IDX_W = 4;
  localparam int SEC_W     = 36;
  localparam int SLEN_W    = 16;
  localparam int OFF_W     = 40;
  localparam int LEN_W     = 24;
  localparam int ADDR_W    = 45;
  localparam int XFER_W    = SLEN_W + SECTOR_SHIFT;
  localparam int CNT_W     = 5;
  localparam int SUM_W     = SLEN_W + CNT_W;
  localparam int SB_W      = SUM_W + SECTOR_SHIFT;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_UPDATE = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MERGE_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILE_SIZE     = 2'd2;

  typedef enum logic [2:0] {
    CMD_RMW    = 3'd0,
    CMD_MLOAD  = 3'd1,
    CMD_MHIT   = 3'd2,
    CMD_DIRECT = 3'd3,
    CMD_FLUSH  = 3'd4,
    CMD_CAPERR = 3'd5,
    CMD_NONE   = 3'd6
  } cmd_kind_t;

endpackage

`default_nettype wire

// ----- src/track_segment_write_splitter_unit.sv -----
`default_nettype none

// channel  dir  handshake             word
// in_      in   in_valid / in_ready   one request (load, update or flush)
// out_     out  out_valid / out_ready one command, out_last on the final one
// cfg_     in   cfg_valid / cfg_ready register index and write data, always ready
//
// Load: the table entry is written when accepted. Update: sum the capacity of the used
// segments, check the file size against it, then walk them, one command per top- or
// bottom-track piece. Flush: one write per dirty buffer. Both end with a final word.
// The segment table is one memory read once per cycle by the sequencer.
// rst_n is synchronous; it clears the sequencer, buffer marks and config registers.
// A stalled output word holds the sequencer at its next command.

module track_segment_write_splitter_unit #(
  parameter int MAX_SEGMENTS = tsws_pkg::MAX_SEGMENTS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [1:0]                        in_req_type,
  input  wire  [tsws_pkg::SEG_IDX_W-1:0]    in_segment_index,
  input  wire                               in_is_bottom,
  input  wire  [tsws_pkg::SEC_W-1:0]        in_sector_start,
  input  wire  [tsws_pkg::SLEN_W-1:0]       in_sector_length,
  input  wire  [tsws_pkg::OFF_W-1:0]        in_update_offset,
  input  wire  [tsws_pkg::LEN_W-1:0]        in_update_length,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [2:0]                        out_command_kind,
  output logic [tsws_pkg::SEG_IDX_W-1:0]    out_piece_segment,
  output logic [tsws_pkg::ADDR_W-1:0]       out_device_address,
  output logic [tsws_pkg::XFER_W-1:0]       out_transfer_bytes,
  output logic [tsws_pkg::XFER_W-1:0]       out_track_offset,
  output logic [tsws_pkg::LEN_W-1:0]        out_source_offset,
  output logic [tsws_pkg::LEN_W-1:0]        out_piece_length,
  output logic [tsws_pkg::XFER_W-1:0]       out_valid_bytes,
  output logic                              out_last,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [tsws_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [tsws_pkg::OFF_W-1:0]        cfg_data
);
  import tsws_pkg::*;

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int UW = (CW > CNT_W) ? CW : CNT_W;

  typedef struct packed {
    logic              bottom;
    logic [SEC_W-1:0]  first_sector;
    logic [SLEN_W-1:0] sectors;
  } seg_entry_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [SEG_IDX_W-1:0] seg;
    logic [ADDR_W-1:0]  addr;
    logic [XFER_W-1:0]  xfer;
    logic [XFER_W-1:0]  toff;
    logic [LEN_W-1:0]   soff;
    logic [LEN_W-1:0]   plen;
    logic [XFER_W-1:0]  vbytes;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_CHECK,
    S_WALK,
    S_RANGE,
    S_PIECE,
    S_BOT_SIZE,
    S_BOT_VALID,
    S_COMMIT,
    S_FLUSH,
    S_FIN
  } state_t;

  seg_entry_t seg_mem [MAX_SEGMENTS];
  seg_entry_t rd_r;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      used_r, used_nxt;
  logic [SUM_W-1:0]   acc_r, acc_nxt;
  logic [SB_W-1:0]    seg_start_r, seg_start_nxt;
  logic [SB_W-1:0]    seg_end_r, seg_end_nxt;
  logic [OFF_W-1:0]   off_r, off_nxt;
  logic [OFF_W:0]     end_r, end_nxt;
  logic [OFF_W-1:0]   os_r, os_nxt;
  logic [SB_W-1:0]    oe_r, oe_nxt;
  logic [SB_W-1:0]    as_r, as_nxt;
  logic [SB_W-1:0]    ae_r, ae_nxt;
  logic               fs_gt_r, fs_gt_nxt;
  logic [OFF_W-1:0]   rest_r, rest_nxt;
  logic               flush_r, flush_nxt;
  result_t            piece_r, piece_nxt;
  result_t            pend_r, pend_nxt;
  logic               pend_v_r, pend_v_nxt;
  result_t            out_r, out_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [MAX_SEGMENTS-1:0] loaded_r, loaded_nxt;
  logic [MAX_SEGMENTS-1:0] dirty_r, dirty_nxt;

  logic               merge_r;
  logic [CNT_W-1:0]   segcnt_r;
  logic [OFF_W-1:0]   fsize_r;

  logic               in_acc;
  logic               load_we;
  logic               slot_free;
  logic [CW-1:0]      used_now;
  logic [ADDR_W-1:0]  rd_base;
  logic [XFER_W-1:0]  rd_cap;
  logic [SB_W-1:0]    os_low;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign load_we   = in_acc && (in_req_type == REQ_LOAD) &&
                     (int'(in_segment_index) < MAX_SEGMENTS);
  assign slot_free = !out_valid_r || out_ready;
  assign used_now  = (UW'(segcnt_r) > UW'(MAX_SEGMENTS)) ? CW'(MAX_SEGMENTS)
                                                          : CW'(segcnt_r);
  assign rd_base   = {rd_r.first_sector, {SECTOR_SHIFT{1'b0}}};
  assign rd_cap    = {rd_r.sectors, {SECTOR_SHIFT{1'b0}}};
  assign os_low    = os_r[SB_W-1:0];

  // segment table
  always_ff @(posedge clk) begin
    if (load_we) begin
      seg_mem[IW'(in_segment_index)] <= '{bottom: in_is_bottom,
                                           first_sector: in_sector_start,
                                           sectors: in_sector_length};
    end
    rd_r <= seg_mem[idx_nxt[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      merge_r  <= 1'b0;
      segcnt_r <= '0;
      fsize_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MERGE_MODE:    merge_r  <= cfg_data[0];
        REG_SEGMENT_COUNT: segcnt_r <= cfg_data[CNT_W-1:0];
        REG_FILE_SIZE:     fsize_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    used_nxt      = used_r;
    acc_nxt       = acc_r;
    seg_start_nxt = seg_start_r;
    seg_end_nxt   = seg_end_r;
    off_nxt       = off_r;
    end_nxt       = end_r;
    os_nxt        = os_r;
    oe_nxt        = oe_r;
    as_nxt        = as_r;
    ae_nxt        = ae_r;
    fs_gt_nxt     = fs_gt_r;
    rest_nxt      = rest_r;
    flush_nxt     = flush_r;
    piece_nxt     = piece_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    out_nxt       = out_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    loaded_nxt    = loaded_r;
    dirty_nxt     = dirty_r;

    case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (in_acc) begin
          case (in_req_type)
            REQ_UPDATE: begin
              off_nxt   = in_update_offset;
              end_nxt   = (OFF_W+1)'(in_update_offset) + (OFF_W+1)'(in_update_length);
              used_nxt  = used_now;
              acc_nxt   = '0;
              flush_nxt = 1'b0;
              state_nxt = S_SUM;
            end
            REQ_FLUSH: begin
              flush_nxt = 1'b1;
              state_nxt = S_FLUSH;
            end
            default: ;
          endcase
        end
      end

      S_SUM: begin
        if (idx_r < used_r) begin
          acc_nxt = acc_r + SUM_W'(rd_r.sectors);
          idx_nxt = idx_r + 1'b1;
        end else begin
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        idx_nxt       = '0;
        seg_start_nxt = '0;
        if (fsize_r > OFF_W'({acc_r, {SECTOR_SHIFT{1'b0}}})) begin
          pend_nxt      = '0;
          pend_nxt.kind = CMD_CAPERR;
          pend_v_nxt    = 1'b1;
          state_nxt     = S_FIN;
        end else begin
          state_nxt = S_WALK;
        end
      end

      S_WALK: begin
        if ((idx_r < used_r) && ((OFF_W+1)'(seg_start_r) < end_r)) begin
          seg_end_nxt = seg_start_r + SB_W'(rd_cap);
          os_nxt      = (off_r > OFF_W'(seg_start_r)) ? off_r : OFF_W'(seg_start_r);
          state_nxt   = S_RANGE;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_RANGE: begin
        oe_nxt    = (end_r < (OFF_W+1)'(seg_end_r)) ? SB_W'(end_r) : seg_end_r;
        state_nxt = S_PIECE;
      end

      S_PIECE: begin
        if (OFF_W'(oe_r) > os_r) begin
          piece_nxt.seg    = SEG_IDX_W'(idx_r);
          piece_nxt.soff   = LEN_W'(os_r - off_r);
          piece_nxt.plen   = LEN_W'(OFF_W'(oe_r) - os_r);
          piece_nxt.addr   = rd_base;
          piece_nxt.vbytes = '0;
          as_nxt = {os_low[SB_W-1:SECTOR_SHIFT], {SECTOR_SHIFT{1'b0}}};
          ae_nxt = {oe_r[SB_W-1:SECTOR_SHIFT] +
                    (SB_W-SECTOR_SHIFT)'(|oe_r[SECTOR_SHIFT-1:0]),
                    {SECTOR_SHIFT{1'b0}}};
          if (!rd_r.bottom) begin
            piece_nxt.toff = XFER_W'(os_low - seg_start_r);
            piece_nxt.xfer = rd_cap;
            if (!merge_r) begin
              piece_nxt.kind = CMD_RMW;
            end else if (!loaded_r[idx_r[IW-1:0]]) begin
              piece_nxt.kind = CMD_MLOAD;
            end else begin
              piece_nxt.kind = CMD_MHIT;
              piece_nxt.xfer = '0;
            end
            state_nxt = S_COMMIT;
          end else begin
            piece_nxt.kind = CMD_DIRECT;
            state_nxt      = S_BOT_SIZE;
          end
        end else begin
          seg_start_nxt = seg_end_r;
          idx_nxt       = idx_r + 1'b1;
          state_nxt     = S_WALK;
        end
      end

      S_BOT_SIZE: begin
        piece_nxt.xfer = XFER_W'(ae_r - as_r);
        piece_nxt.toff = XFER_W'(as_r - seg_start_r);
        fs_gt_nxt      = fsize_r > OFF_W'(as_r);
        rest_nxt       = fsize_r - OFF_W'(as_r);
        state_nxt      = S_BOT_VALID;
      end

      S_BOT_VALID: begin
        piece_nxt.addr = rd_base + ADDR_W'(piece_r.toff);
        if (!fs_gt_r) begin
          piece_nxt.vbytes = '0;
        end else if (rest_r < OFF_W'(piece_r.xfer)) begin
          piece_nxt.vbytes = XFER_W'(rest_r);
        end else begin
          piece_nxt.vbytes = piece_r.xfer;
        end
        state_nxt = S_COMMIT;
      end

      S_COMMIT: begin
        if (!pend_v_r || slot_free) begin
          if (pend_v_r) begin
            out_nxt       = pend_r;
            out_last_nxt  = 1'b0;
            out_valid_nxt = 1'b1;
          end
          pend_nxt   = piece_r;
          pend_v_nxt = 1'b1;
          if (piece_r.kind == CMD_MLOAD) begin
            loaded_nxt[idx_r[IW-1:0]] = 1'b1;
            dirty_nxt[idx_r[IW-1:0]]  = 1'b1;
          end else if (piece_r.kind == CMD_MHIT) begin
            dirty_nxt[idx_r[IW-1:0]] = 1'b1;
          end
          idx_nxt = idx_r + 1'b1;
          if (flush_r) begin
            state_nxt = S_FLUSH;
          end else begin
            seg_start_nxt = seg_end_r;
            state_nxt     = S_WALK;
          end
        end
      end

      S_FLUSH: begin
        if (idx_r == CW'(MAX_SEGMENTS)) begin
          state_nxt = S_FIN;
        end else if (dirty_r[idx_r[IW-1:0]]) begin
          piece_nxt      = '0;
          piece_nxt.kind = CMD_FLUSH;
          piece_nxt.seg  = SEG_IDX_W'(idx_r);
          piece_nxt.addr = rd_base;
          piece_nxt.xfer = rd_cap;
          state_nxt      = S_COMMIT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_FIN: begin
        if (slot_free) begin
          if (pend_v_r) begin
            out_nxt = pend_r;
          end else begin
            out_nxt      = '0;
            out_nxt.kind = CMD_NONE;
          end
          out_last_nxt  = 1'b1;
          out_valid_nxt = 1'b1;
          pend_v_nxt    = 1'b0;
          if (flush_r) begin
            loaded_nxt = '0;
            dirty_nxt  = '0;
          end
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      loaded_r    <= '0;
      dirty_r     <= '0;
      flush_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      loaded_r    <= loaded_nxt;
      dirty_r     <= dirty_nxt;
      flush_r     <= flush_nxt;
    end
    used_r      <= used_nxt;
    acc_r       <= acc_nxt;
    seg_start_r <= seg_start_nxt;
    seg_end_r   <= seg_end_nxt;
    off_r       <= off_nxt;
    end_r       <= end_nxt;
    os_r        <= os_nxt;
    oe_r        <= oe_nxt;
    as_r        <= as_nxt;
    ae_r        <= ae_nxt;
    fs_gt_r     <= fs_gt_nxt;
    rest_r      <= rest_nxt;
    piece_r     <= piece_nxt;
    pend_r      <= pend_nxt;
    out_r       <= out_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_command_kind   = out_r.kind;
  assign out_piece_segment  = out_r.seg;
  assign out_device_address = out_r.addr;
  assign out_transfer_bytes = out_r.xfer;
  assign out_track_offset   = out_r.toff;
  assign out_source_offset  = out_r.soff;
  assign out_piece_length   = out_r.plen;
  assign out_valid_bytes    = out_r.vbytes;
  assign out_last           = out_last_r;

endmodule

`default_nettype wire

// ----- src/tsws_checker.sv -----
`default_nettype none

module tsws_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            out_valid,
  input wire                            out_ready,
  input wire [2:0]                      out_command_kind,
  input wire [tsws_pkg::ADDR_W-1:0]     out_device_address,
  input wire [tsws_pkg::XFER_W-1:0]     out_transfer_bytes,
  input wire [tsws_pkg::XFER_W-1:0]     out_track_offset,
  input wire [tsws_pkg::LEN_W-1:0]      out_source_offset,
  input wire [tsws_pkg::LEN_W-1:0]      out_piece_length,
  input wire [tsws_pkg::XFER_W-1:0]     out_valid_bytes,
  input wire                            out_last
);
  import tsws_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_command_kind) &&
      $stable(out_device_address) && $stable(out_last))
    else $error("output word changed while stalled");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_command_kind == CMD_NONE || out_command_kind == CMD_CAPERR) |->
      out_last && out_device_address == '0 && out_transfer_bytes == '0)
    else $error("none or capacity error word is not a lone final word");

  a_hit_no_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command_kind == CMD_MHIT |->
      out_transfer_bytes == '0 && out_valid_bytes == '0)
    else $error("merged hit moves device bytes");

  a_direct_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command_kind == CMD_DIRECT |->
      out_track_offset[SECTOR_SHIFT-1:0] == '0 &&
      out_transfer_bytes[SECTOR_SHIFT-1:0] == '0 &&
      out_valid_bytes <= out_transfer_bytes)
    else $error("direct write not sector aligned or valid bytes too large");

  a_flush_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_command_kind == CMD_FLUSH |->
      out_track_offset == '0 && out_source_offset == '0 && out_piece_length == '0)
    else $error("flush write carries piece fields");

endmodule

bind track_segment_write_splitter_unit tsws_checker u_tsws_checker (.*);

`default_nettype wire
